// ===== sv/rtmr_pkg.sv =====
// Shared types and constants for the residue to mixed-radix converter.
`default_nettype none
package rtmr_pkg;

  // Widths of the payload fields and of the arithmetic.
  localparam int MOD_W = 31;
  localparam int POS_W = 4;
  localparam int DVD_W = 2 * MOD_W + 1;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int X_W   = MOD_W + 3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WAIT,
    S_PRD_RD,
    S_PRD_OP,
    S_EU_CHK,
    S_EU_WAIT,
    S_EU_FIN,
    S_BAD,
    S_VAL_RD,
    S_VAL_OP,
    S_DIG,
    S_STORE,
    S_EMIT
  } state_t;

  // Which step a shared multiply and reduce belongs to.
  typedef enum logic [2:0] {
    OP_RES,
    OP_PROD,
    OP_BAD,
    OP_VAL,
    OP_DIG
  } op_t;

endpackage
`default_nettype wire

// ===== sv/rtmr_in_if.sv =====
// Request channel carrying one residue and its modulus.
`default_nettype none
interface rtmr_in_if
  import rtmr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             first;
  logic [MOD_W-1:0] modulus;
  logic [MOD_W-1:0] residue;

  modport source (output valid, first, modulus, residue, input ready);
  modport sink (input valid, first, modulus, residue, output ready);
endinterface
`default_nettype wire

// ===== sv/rtmr_out_if.sv =====
// Result channel carrying one mixed-radix digit and its flags.
`default_nettype none
interface rtmr_out_if
  import rtmr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] digit;
  logic [POS_W-1:0] position;
  logic             inverse_bad;
  logic             overflow;

  modport source (output valid, digit, position, inverse_bad, overflow, input ready);
  modport sink (input valid, digit, position, inverse_bad, overflow, output ready);
endinterface
`default_nettype wire

// ===== sv/rtmr_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rtmr_div
  import rtmr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [MOD_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient,
  output logic [MOD_W-1:0]      remainder
);

  logic [MOD_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [MOD_W:0]   shifted;
  logic [MOD_W:0]   diff;
  logic             ge;

  // One shift and conditional subtract step.
  always_comb begin
    shifted = {remainder, quotient[DVD_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DVD_W-2:0], ge};
      remainder <= ge ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/rtmr_store.sv =====
// Moduli and digit memories with one write port and a registered read.
`default_nettype none
module rtmr_store
  import rtmr_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [MOD_W-1:0] wr_mod,
  input  wire logic [MOD_W-1:0] wr_dig,
  input  wire logic [AW-1:0]    rd_addr,
  output logic [MOD_W-1:0]      rd_mod,
  output logic [MOD_W-1:0]      rd_dig
);

  logic [MOD_W-1:0] mod_mem [DEPTH];
  logic [MOD_W-1:0] dig_mem [DEPTH];

  // Write both entries of one position together.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mod_mem[wr_addr] <= wr_mod;
      dig_mem[wr_addr] <= wr_dig;
    end
  end

  // Read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_mod <= mod_mem[rd_addr];
    rd_dig <= dig_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/rns_to_mixed_radix.sv =====
// Top level of the residue number system to mixed-radix digit converter.
//
// Requests arrive on the item channel: a residue, its modulus and a first
// flag that starts a new number at position zero. Each request yields one
// result on the result channel: the mixed-radix digit, its position and
// flags for a failed inverse and for a full store.
// Earlier moduli and digits sit in two memories of MAX_MODULI entries.
// Every modular product goes through one restoring divider of 63 steps.
// One request is worked on at a time; a new one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, the finished result waits in the sequencer
// until the output register is free.
// Reset clears the position counter and empties the output register; the
// memories need no clearing since only entries of the current number are read.
`default_nettype none
module rns_to_mixed_radix
  import rtmr_pkg::*;
#(
  parameter int MAX_MODULI = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rtmr_in_if.sink    item,
  rtmr_out_if.source result
);

  localparam int AW = $clog2(MAX_MODULI);
  localparam int PW = $clog2(MAX_MODULI + 1);

  state_t state, state_next;
  op_t    op;

  logic [PW-1:0]      next_position;
  logic [PW-1:0]      p_in;
  logic [AW-1:0]      p, j, k;
  logic               ovf, bad, vinit;
  logic [MOD_W-1:0]   m, r, prod, inv, val, digit;
  logic [MOD_W-1:0]   opa, opb, opc;
  logic [DVD_W-1:0]   mac;
  logic [MOD_W-1:0]   ra, rb;
  logic signed [X_W-1:0] x, lx, x_next, qs, lx_pos, m_s, inv_fin;
  logic [MOD_W:0]     dsub;

  logic               div_start, div_busy, div_done;
  logic [DVD_W-1:0]   div_dvd, div_quot;
  logic [MOD_W-1:0]   div_dvs, div_rem;

  logic [AW-1:0]      rd_addr;
  logic [MOD_W-1:0]   rd_mod, rd_dig;
  logic               wr_en;
  logic               slot_free;

  // Shared divider for all reductions and Euclid quotients.
  rtmr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Stored moduli and digits of the current number.
  rtmr_store #(.DEPTH(MAX_MODULI)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (p),
    .wr_mod  (m),
    .wr_dig  (digit),
    .rd_addr (rd_addr),
    .rd_mod  (rd_mod),
    .rd_dig  (rd_dig)
  );

  // Datapath helpers.
  always_comb begin
    p_in      = item.first ? '0 : next_position;
    slot_free = !result.valid || result.ready;
    item.ready = (state == S_IDLE);
    wr_en     = (state == S_STORE);
    rd_addr   = (state == S_VAL_RD) ? k : j;
    div_start = (state == S_DIV) || (state == S_EU_CHK && rb != '0);
    div_dvd   = (state == S_DIV) ? mac : DVD_W'(ra);
    div_dvs   = (state == S_DIV) ? m : rb;
    qs        = X_W'($signed({1'b0, div_quot[MOD_W-1:0]}));
    x_next    = lx - qs * x;
    m_s       = $signed({3'b000, m});
    lx_pos    = (lx < 0) ? lx + m_s : lx;
    inv_fin   = (lx_pos >= m_s) ? lx_pos - m_s : lx_pos;
    dsub      = {1'b0, r} - {1'b0, val} + ((r < val) ? {1'b0, m} : '0);
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          if (p_in >= PW'(MAX_MODULI)) state_next = S_EMIT;
          else if (item.modulus == '0) state_next = S_STORE;
          else state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_DIV;
      S_DIV:  state_next = S_WAIT;
      S_WAIT: begin
        if (div_done) begin
          unique case (op)
            OP_RES, OP_PROD: state_next = S_PRD_RD;
            OP_BAD:  state_next = (p == '0) ? S_STORE : S_VAL_RD;
            OP_VAL:  state_next = (k == '0) ? S_DIG : S_VAL_RD;
            OP_DIG:  state_next = S_STORE;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_PRD_RD: begin
        if (j == p) state_next = (p == '0) ? S_BAD : S_EU_CHK;
        else state_next = S_PRD_OP;
      end
      S_PRD_OP:  state_next = S_MUL;
      S_EU_CHK:  state_next = (rb == '0) ? S_EU_FIN : S_EU_WAIT;
      S_EU_WAIT: if (div_done) state_next = S_EU_CHK;
      S_EU_FIN:  state_next = S_BAD;
      S_BAD:     state_next = S_MUL;
      S_VAL_RD:  state_next = S_VAL_OP;
      S_VAL_OP:  state_next = S_MUL;
      S_DIG:     state_next = S_MUL;
      S_STORE:   state_next = S_EMIT;
      S_EMIT:    if (slot_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Working registers of the digit computation.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          m     <= item.modulus;
          r     <= item.residue;
          p     <= AW'(p_in);
          ovf   <= p_in >= PW'(MAX_MODULI);
          bad   <= item.modulus == '0;
          digit <= '0;
          j     <= '0;
          opa   <= '0;
          opb   <= '0;
          opc   <= item.residue;
          op    <= OP_RES;
        end
      end
      S_MUL: mac <= DVD_W'(opa) * DVD_W'(opb) + DVD_W'(opc);
      S_WAIT: begin
        if (div_done) begin
          unique case (op)
            OP_RES: begin
              r    <= div_rem;
              prod <= MOD_W'(m != MOD_W'(1));
            end
            OP_PROD: begin
              prod <= div_rem;
              j    <= j + AW'(1);
            end
            OP_BAD: begin
              bad   <= div_rem != MOD_W'(1);
              digit <= r;
              k     <= p - AW'(1);
              vinit <= 1'b1;
            end
            OP_VAL: begin
              val   <= div_rem;
              vinit <= 1'b0;
              if (k != '0) k <= k - AW'(1);
            end
            OP_DIG:  digit <= div_rem;
            default: digit <= '0;
          endcase
        end
      end
      S_PRD_RD: begin
        if (j == p) begin
          inv <= prod;
          ra  <= prod;
          rb  <= m;
          x   <= '0;
          lx  <= X_W'(1);
        end
      end
      S_PRD_OP: begin
        opa <= prod;
        opb <= rd_mod;
        opc <= '0;
        op  <= OP_PROD;
      end
      S_EU_WAIT: begin
        if (div_done) begin
          ra <= rb;
          rb <= div_rem;
          lx <= x;
          x  <= x_next;
        end
      end
      S_EU_FIN: inv <= inv_fin[MOD_W-1:0];
      S_BAD: begin
        opa <= prod;
        opb <= inv;
        opc <= '0;
        op  <= OP_BAD;
      end
      S_VAL_OP: begin
        opa <= vinit ? '0 : val;
        opb <= vinit ? '0 : rd_mod;
        opc <= rd_dig;
        op  <= OP_VAL;
      end
      S_DIG: begin
        opa <= dsub[MOD_W-1:0];
        opb <= inv;
        opc <= '0;
        op  <= OP_DIG;
      end
      default: ;
    endcase
  end

  // Position counter of the current number.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_position <= '0;
    end else if (state == S_STORE) begin
      next_position <= PW'(p) + PW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_EMIT && slot_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && slot_free) begin
      result.digit       <= ovf ? '0 : digit;
      result.position    <= ovf ? POS_W'(MAX_MODULI - 1) : POS_W'(p);
      result.inverse_bad <= ovf ? 1'b0 : bad;
      result.overflow    <= ovf;
    end
  end

  // The divider is never restarted while it is still working.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // Storing a position advances the counter past it.
  a_pos_adv: assert property (@(posedge clk) disable iff (rst)
    state == S_STORE |=> next_position == PW'($past(p)) + PW'(1))
    else $error("position counter did not advance");

  // An overflow result carries a zero digit and no inverse flag.
  a_ovf_res: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflow |-> result.digit == '0 && !result.inverse_bad)
    else $error("overflow result carries data");

  // Nothing is written to the store for an overflowing request.
  a_no_ovf_wr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !ovf)
    else $error("store written on overflow");

endmodule
`default_nettype wire
